[rtl/fhm_pkg.sv]
// Shared types and constants of the mutex table manager.
// No dependencies; every other file imports this package.
package fhm_pkg;

    localparam int FUNC_W     = 3;
    localparam int HANDLE_W   = 5;
    localparam int TID_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int TDATA_W    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W  = 5;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOCK    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNLOCK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DESTROY = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RELALL  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_ABORT   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY_SELF  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DENIED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WAITING    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd5;

    // Result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_WAKE  = 1'b1;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_LOCK,
        OP_UNLOCK,
        OP_DESTROY,
        OP_RELALL,
        OP_ABORT,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
        logic [TID_W-1:0]    tid;
    } req_t;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    thread;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ADD_RD,
        S_ADD_CHK,
        S_RM_RD,
        S_RM_CHK,
        S_RM_MV,
        S_HANDOFF,
        S_DPOP,
        S_REL_TOP,
        S_REL_CHK,
        S_REPLY
    } state_t;

endpackage

[rtl/fhm_front.sv]
// Front end: accepts request transactions, classifies them and queues them.
// Depends on fhm_pkg.
module fhm_front #(
    parameter int THREADS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fhm_pkg::TDATA_W-1:0] s_tdata,   // func[2:0], handle[7:3], thread_id[11:8]
    output logic                        req_valid,
    input  logic                        req_ready,
    output fhm_pkg::req_t               req
);
    import fhm_pkg::*;

    req_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    req_t       cls;

    logic [FUNC_W-1:0]   in_func;
    logic [HANDLE_W-1:0] in_handle;
    logic [TID_W-1:0]    in_tid;

    assign in_func   = s_tdata[2:0];
    assign in_handle = s_tdata[7:3];
    assign in_tid    = s_tdata[11:8];

    // Classify the incoming request
    always_comb begin
        cls.handle = in_handle;
        cls.tid    = in_tid;
        if (in_func == FUNC_CREATE) begin
            cls.op = OP_CREATE;
        end else if (in_func > FUNC_ABORT || int'(in_tid) >= THREADS) begin
            cls.op = OP_BAD;
        end else begin
            case (in_func)
                FUNC_LOCK:    cls.op = OP_LOCK;
                FUNC_UNLOCK:  cls.op = OP_UNLOCK;
                FUNC_DESTROY: cls.op = OP_DESTROY;
                FUNC_RELALL:  cls.op = OP_RELALL;
                FUNC_ABORT:   cls.op = OP_ABORT;
                default:      cls.op = OP_BAD;
            endcase
        end
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = req_valid && req_ready;

    // Hold classified requests
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

[rtl/fhm_out.sv]
// Result queue: buffers result transactions and drives the master side.
// Depends on fhm_pkg.
module fhm_out (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        res_we,
    input  fhm_pkg::res_t               res,
    output logic                        res_space,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fhm_pkg::TDATA_W-1:0] m_tdata,   // status[2:0], thread_out[6:3], handle_out[11:7]
    output logic                        m_tuser,   // kind[0]
    output logic                        m_tlast
);
    import fhm_pkg::*;

    res_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;
    res_t       head;

    assign res_space = (cnt_reg != 2'd2);
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign pop       = m_tvalid && m_tready;
    assign head      = q_reg[rd_ptr_reg];

    // Pack the head result onto the bus
    assign m_tdata = {4'b0000, head.handle, head.thread, head.status};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // Hold results
    always_ff @(posedge aclk) begin
        if (res_we) begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (res_we) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({res_we, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

[rtl/fhm_engine.sv]
// Back end: mutex table, waiter queues and held lists, run by a sequencer.
// Depends on fhm_pkg; fed by fhm_front, feeds fhm_out.
module fhm_engine #(
    parameter int MUTEXES         = 16,
    parameter int THREADS         = 16,
    parameter int HELD_PER_THREAD = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  fhm_pkg::req_t req,
    output logic          res_we,
    output fhm_pkg::res_t res,
    input  logic          res_space
);
    import fhm_pkg::*;

    localparam int MIW   = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
    localparam int TIW   = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW    = $clog2(HELD_PER_THREAD + 1);
    localparam int DEPTH = THREADS * HELD_PER_THREAD;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Mutex table
    logic [MUTEXES-1:0] slot_reg, own_v_reg, qne_reg;
    logic [TID_W-1:0]   own_t_reg [MUTEXES];
    logic [TIW-1:0]     qhead_reg [MUTEXES];
    logic [TIW-1:0]     qtail_reg [MUTEXES];

    // Per-thread waiter links and held counts
    logic [TIW-1:0]     wnext_reg [THREADS];
    logic [TIW-1:0]     wprev_reg [THREADS];
    logic [THREADS-1:0] whn_reg, whp_reg, wv_reg;
    logic [MIW-1:0]     wm_reg [THREADS];
    logic [CW-1:0]      hcnt_reg [THREADS];

    // Held-list memory
    logic [HANDLE_W-1:0] held_mem [DEPTH];
    logic [HANDLE_W-1:0] rdata_reg;
    logic [AW-1:0]       raddr, waddr;
    logic                mem_we;
    logic [HANDLE_W-1:0] wdata;

    // Sequencer state
    state_t              state_reg, state_next;
    req_t                req_reg;
    logic [MIW-1:0]      cur_m_reg;
    logic [HANDLE_W-1:0] cur_h_reg;
    logic [TIW-1:0]      scan_thr_reg;
    logic [HANDLE_W-1:0] scan_h_reg;
    logic [CW-1:0]       scan_i_reg, scan_n_reg;
    logic [STATUS_W-1:0] rep_status_reg;
    logic [HANDLE_W-1:0] rep_handle_reg;
    logic [RES_CNT_W-1:0] ecnt_reg;

    // Decode helpers
    logic [TIW-1:0]  t_idx;
    logic [MIW-1:0]  m_idx;
    logic            found, is_owner;
    logic            free_found;
    logic [MIW-1:0]  free_idx;
    logic [TIW-1:0]  hd_w;
    logic            drop, go_emit, do_pop;
    logic [MIW-1:0]  hm;
    logic            rel_ok;
    logic [AW-1:0]   scan_base, rel_base;
    logic [CW-1:0]   rel_n;
    state_t          add_done, rm_done;

    assign t_idx    = TIW'(req_reg.tid);
    assign m_idx    = MIW'(req_reg.handle - HANDLE_W'(1));
    assign found    = (req_reg.handle != '0) && (int'(req_reg.handle) <= MUTEXES)
                      && slot_reg[m_idx];
    assign is_owner = own_v_reg[m_idx] && (own_t_reg[m_idx] == req_reg.tid);

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MUTEXES - 1; i >= 0; i--) begin
            if (!slot_reg[i]) begin
                free_found = 1'b1;
                free_idx   = MIW'(i);
            end
        end
    end

    assign hd_w    = qhead_reg[cur_m_reg];
    assign drop    = (ecnt_reg >= RES_CNT_W'(MAX_RESULTS));
    assign go_emit = res_space || drop;
    assign do_pop  = ((state_reg == S_HANDOFF) || (state_reg == S_DPOP))
                     && qne_reg[cur_m_reg] && go_emit;

    assign hm     = MIW'(rdata_reg - HANDLE_W'(1));
    assign rel_ok = (rdata_reg != '0) && (int'(rdata_reg) <= MUTEXES) && slot_reg[hm]
                    && own_v_reg[hm] && (own_t_reg[hm] == req_reg.tid);
    assign rel_n  = hcnt_reg[t_idx];

    assign scan_base = AW'(scan_thr_reg) * AW'(HELD_PER_THREAD);
    assign rel_base  = AW'(t_idx) * AW'(HELD_PER_THREAD);

    assign add_done = (req_reg.op == OP_RELALL) ? S_REL_TOP : S_REPLY;
    assign rm_done  = (req_reg.op == OP_UNLOCK) ? S_HANDOFF : S_DPOP;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (req_reg.op)
                    OP_LOCK: begin
                        if (found && !is_owner && !own_v_reg[m_idx]) begin
                            state_next = S_ADD_RD;
                        end else begin
                            state_next = S_REPLY;
                        end
                    end
                    OP_UNLOCK: begin
                        state_next = (found && is_owner) ? S_RM_RD : S_REPLY;
                    end
                    OP_DESTROY: begin
                        if (!found) begin
                            state_next = S_REPLY;
                        end else if (own_v_reg[m_idx]) begin
                            state_next = S_RM_RD;
                        end else begin
                            state_next = S_DPOP;
                        end
                    end
                    OP_RELALL: state_next = S_REL_TOP;
                    default:   state_next = S_REPLY;
                endcase
            end
            S_ADD_RD:  state_next = (scan_i_reg < scan_n_reg) ? S_ADD_CHK : add_done;
            S_ADD_CHK: state_next = (rdata_reg == scan_h_reg) ? add_done : S_ADD_RD;
            S_RM_RD:   state_next = (scan_i_reg < scan_n_reg) ? S_RM_CHK : rm_done;
            S_RM_CHK:  state_next = (rdata_reg == scan_h_reg) ? S_RM_MV : S_RM_RD;
            S_RM_MV:   state_next = rm_done;
            S_HANDOFF: begin
                if (qne_reg[cur_m_reg]) begin
                    if (go_emit) begin
                        state_next = S_ADD_RD;
                    end
                end else begin
                    state_next = (req_reg.op == OP_RELALL) ? S_REL_TOP : S_REPLY;
                end
            end
            S_DPOP: begin
                if (!qne_reg[cur_m_reg]) begin
                    state_next = S_REPLY;
                end
            end
            S_REL_TOP: state_next = (rel_n != '0) ? S_REL_CHK : S_REPLY;
            S_REL_CHK: state_next = rel_ok ? S_HANDOFF : S_REL_TOP;
            S_REPLY: begin
                if (go_emit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: handshake, results and memory ports
    always_comb begin
        req_ready = (state_reg == S_IDLE);
        res_we    = 1'b0;
        res       = '0;
        raddr     = scan_base + AW'(scan_i_reg);
        mem_we    = 1'b0;
        waddr     = scan_base + AW'(scan_n_reg);
        wdata     = scan_h_reg;
        case (state_reg)
            S_ADD_RD: begin
                if (!(scan_i_reg < scan_n_reg) && int'(scan_n_reg) < HELD_PER_THREAD) begin
                    mem_we = 1'b1;
                end
            end
            S_RM_CHK: raddr = scan_base + AW'(scan_n_reg) - AW'(1);
            S_RM_MV: begin
                mem_we = 1'b1;
                waddr  = scan_base + AW'(scan_i_reg);
                wdata  = rdata_reg;
            end
            S_HANDOFF: begin
                if (qne_reg[cur_m_reg] && !drop) begin
                    res_we     = res_space;
                    res.kind   = KIND_WAKE;
                    res.status = ST_OK;
                    res.thread = TID_W'(hd_w);
                    res.handle = cur_h_reg;
                    res.last   = 1'b0;
                end
            end
            S_DPOP: begin
                if (qne_reg[cur_m_reg] && !drop) begin
                    res_we     = res_space;
                    res.kind   = KIND_WAKE;
                    res.status = ST_NOT_FOUND;
                    res.thread = TID_W'(hd_w);
                    res.handle = req_reg.handle;
                    res.last   = 1'b0;
                end
            end
            S_REL_TOP: raddr = rel_base + AW'(rel_n) - AW'(1);
            S_REPLY: begin
                if (!drop) begin
                    res_we     = res_space;
                    res.kind   = KIND_REPLY;
                    res.status = rep_status_reg;
                    res.thread = req_reg.tid;
                    res.handle = rep_handle_reg;
                    res.last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Held-list memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            held_mem[waddr] <= wdata;
        end
        rdata_reg <= held_mem[raddr];
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Table updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            own_v_reg <= '0;
            qne_reg   <= '0;
            whn_reg   <= '0;
            whp_reg   <= '0;
            wv_reg    <= '0;
            ecnt_reg  <= '0;
            for (int i = 0; i < MUTEXES; i++) begin
                own_t_reg[i] <= '0;
            end
            for (int i = 0; i < THREADS; i++) begin
                hcnt_reg[i] <= '0;
            end
        end else begin
            if (res_we) begin
                ecnt_reg <= ecnt_reg + RES_CNT_W'(1);
            end
            case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        req_reg  <= req;
                        ecnt_reg <= '0;
                    end
                end
                S_EXEC: begin
                    rep_status_reg <= ST_OK;
                    rep_handle_reg <= req_reg.handle;
                    cur_m_reg      <= m_idx;
                    cur_h_reg      <= req_reg.handle;
                    scan_h_reg     <= req_reg.handle;
                    scan_i_reg     <= '0;
                    scan_thr_reg   <= t_idx;
                    scan_n_reg     <= hcnt_reg[t_idx];
                    case (req_reg.op)
                        OP_CREATE: begin
                            if (free_found) begin
                                slot_reg[free_idx]  <= 1'b1;
                                own_v_reg[free_idx] <= 1'b0;
                                own_t_reg[free_idx] <= '0;
                                qne_reg[free_idx]   <= 1'b0;
                                rep_handle_reg      <= HANDLE_W'(int'(free_idx) + 1);
                            end else begin
                                rep_status_reg <= ST_TABLE_FULL;
                                rep_handle_reg <= '0;
                            end
                        end
                        OP_LOCK: begin
                            if (!found) begin
                                rep_status_reg <= ST_NOT_FOUND;
                            end else if (is_owner) begin
                                rep_status_reg <= ST_BUSY_SELF;
                            end else if (!own_v_reg[m_idx]) begin
                                own_v_reg[m_idx] <= 1'b1;
                                own_t_reg[m_idx] <= req_reg.tid;
                            end else if (wv_reg[t_idx]) begin
                                rep_status_reg <= ST_DENIED;
                            end else begin
                                // Append the requester to the queue tail
                                rep_status_reg   <= ST_WAITING;
                                whn_reg[t_idx]   <= 1'b0;
                                whp_reg[t_idx]   <= qne_reg[m_idx];
                                wprev_reg[t_idx] <= qtail_reg[m_idx];
                                wv_reg[t_idx]    <= 1'b1;
                                wm_reg[t_idx]    <= m_idx;
                                if (qne_reg[m_idx]) begin
                                    wnext_reg[qtail_reg[m_idx]] <= t_idx;
                                    whn_reg[qtail_reg[m_idx]]   <= 1'b1;
                                end else begin
                                    qhead_reg[m_idx] <= t_idx;
                                    qne_reg[m_idx]   <= 1'b1;
                                end
                                qtail_reg[m_idx] <= t_idx;
                            end
                        end
                        OP_UNLOCK: begin
                            if (!found) begin
                                rep_status_reg <= ST_NOT_FOUND;
                            end else if (!is_owner) begin
                                rep_status_reg <= ST_DENIED;
                            end
                        end
                        OP_DESTROY: begin
                            if (!found) begin
                                rep_status_reg <= ST_NOT_FOUND;
                            end else begin
                                scan_thr_reg <= TIW'(own_t_reg[m_idx]);
                                scan_n_reg   <= hcnt_reg[TIW'(own_t_reg[m_idx])];
                            end
                        end
                        OP_RELALL: rep_handle_reg <= '0;
                        OP_ABORT: begin
                            if (wv_reg[t_idx]) begin
                                // Unlink the target from its queue
                                rep_handle_reg <= HANDLE_W'(int'(wm_reg[t_idx]) + 1);
                                if (whp_reg[t_idx]) begin
                                    wnext_reg[wprev_reg[t_idx]] <= wnext_reg[t_idx];
                                    whn_reg[wprev_reg[t_idx]]   <= whn_reg[t_idx];
                                    if (!whn_reg[t_idx]) begin
                                        qtail_reg[wm_reg[t_idx]] <= wprev_reg[t_idx];
                                    end
                                end else if (whn_reg[t_idx]) begin
                                    qhead_reg[wm_reg[t_idx]] <= wnext_reg[t_idx];
                                end else begin
                                    qne_reg[wm_reg[t_idx]] <= 1'b0;
                                end
                                if (whn_reg[t_idx]) begin
                                    whp_reg[wnext_reg[t_idx]]   <= whp_reg[t_idx];
                                    wprev_reg[wnext_reg[t_idx]] <= wprev_reg[t_idx];
                                end
                                whn_reg[t_idx] <= 1'b0;
                                wv_reg[t_idx]  <= 1'b0;
                            end else begin
                                rep_handle_reg <= '0;
                            end
                        end
                        default: begin
                            rep_status_reg <= ST_DENIED;
                            rep_handle_reg <= '0;
                        end
                    endcase
                end
                S_ADD_RD: begin
                    if (!(scan_i_reg < scan_n_reg) && int'(scan_n_reg) < HELD_PER_THREAD) begin
                        hcnt_reg[scan_thr_reg] <= scan_n_reg + CW'(1);
                    end
                end
                S_ADD_CHK, S_RM_CHK: begin
                    if (rdata_reg != scan_h_reg) begin
                        scan_i_reg <= scan_i_reg + CW'(1);
                    end
                end
                S_RM_MV: hcnt_reg[scan_thr_reg] <= scan_n_reg - CW'(1);
                S_HANDOFF: begin
                    if (qne_reg[cur_m_reg]) begin
                        if (go_emit) begin
                            own_t_reg[cur_m_reg] <= TID_W'(hd_w);
                            own_v_reg[cur_m_reg] <= 1'b1;
                            scan_thr_reg         <= hd_w;
                            scan_h_reg           <= cur_h_reg;
                            scan_i_reg           <= '0;
                            scan_n_reg           <= hcnt_reg[hd_w];
                        end
                    end else begin
                        own_v_reg[cur_m_reg] <= 1'b0;
                        own_t_reg[cur_m_reg] <= '0;
                    end
                end
                S_DPOP: begin
                    if (!qne_reg[cur_m_reg]) begin
                        slot_reg[cur_m_reg]  <= 1'b0;
                        own_v_reg[cur_m_reg] <= 1'b0;
                        own_t_reg[cur_m_reg] <= '0;
                    end
                end
                S_REL_CHK: begin
                    hcnt_reg[t_idx] <= rel_n - CW'(1);
                    cur_m_reg       <= hm;
                    cur_h_reg       <= rdata_reg;
                end
                default: ;
            endcase
            // Drop the head waiter from the current queue
            if (do_pop) begin
                if (whn_reg[hd_w]) begin
                    qhead_reg[cur_m_reg]    <= wnext_reg[hd_w];
                    whp_reg[wnext_reg[hd_w]] <= 1'b0;
                end else begin
                    qne_reg[cur_m_reg] <= 1'b0;
                end
                whn_reg[hd_w] <= 1'b0;
                wv_reg[hd_w]  <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_we |-> res_space)
        else $error("result written into a full queue");

    a_take_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req_ready) |=> (state_reg == S_EXEC))
        else $error("request taken but not executed");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD_RD) |-> (int'(scan_n_reg) <= HELD_PER_THREAD))
        else $error("held count above capacity");
`endif

endmodule

[rtl/fifo_handoff_mutex_manager.sv]
// Mutex table manager with FIFO waiter queues and direct ownership handoff.
// A request is taken into a two-entry front queue and executed one at a time
// by a sequencer; results leave through a two-entry result queue. A plain
// request is taken, executed and replied to. A held-list scan compares one
// entry at a time, and a scan that ends without a match appends the handle,
// where there is room. A removal moves the last entry into the freed place,
// and a handoff hands the mutex to the head waiter. Destroy wakes every waiter;
// release-all walks the held list from the top, besides its handoffs. The
// held-list memory has a registered read. A full result queue stalls the
// sequencer until the receiver takes a result, unless results past MAX_RESULTS
// are being dropped. No clearing pass after reset. Depends on fhm_pkg, fhm_front, fhm_engine, fhm_out.
module fifo_handoff_mutex_manager #(
    parameter int MUTEXES         = 16,
    parameter int THREADS         = 16,
    parameter int HELD_PER_THREAD = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fhm_pkg::TDATA_W-1:0] s_tdata,   // func[2:0], handle[7:3], thread_id[11:8]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fhm_pkg::TDATA_W-1:0] m_tdata,   // status[2:0], thread_out[6:3], handle_out[11:7]
    output logic                        m_tuser,   // kind[0]
    output logic                        m_tlast
);
    import fhm_pkg::*;

    req_t req;
    logic req_valid, req_ready;
    res_t res;
    logic res_we, res_space;

    fhm_front #(
        .THREADS (THREADS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    fhm_engine #(
        .MUTEXES         (MUTEXES),
        .THREADS         (THREADS),
        .HELD_PER_THREAD (HELD_PER_THREAD)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_we    (res_we),
        .res       (res),
        .res_space (res_space)
    );

    fhm_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_we    (res_we),
        .res       (res),
        .res_space (res_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
